@@ rtl/core/dgcd_pkg.sv @@
// Shared types and constants for the directed graph cycle detector.
`default_nettype none
package dgcd_pkg;
  localparam int NODE_W  = 8;
  localparam int NODES   = 256;
  localparam int EDGE_W  = 10;
  localparam int EDGES   = 1024;
  localparam int LINK_W  = 11;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Search results handed from the engine to the top level.
  typedef struct packed {
    logic done;
    logic cycle;
  } srch_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/dgcd_engine.sv @@
// Edge store and depth-first search engine of the cycle detector.
`default_nettype none
module dgcd_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [1:0]                    op,
  input  wire logic [dgcd_pkg::NODE_W-1:0]   src,
  input  wire logic [dgcd_pkg::NODE_W-1:0]   dst,
  input  wire logic [dgcd_pkg::NODE_W-1:0]   last_root,
  output logic                               busy,
  output logic                               ovf,
  output dgcd_pkg::srch_sts_t                sts
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLRM  = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_RHEAD = 4'd3;
  localparam logic [3:0] S_TOP   = 4'd4;
  localparam logic [3:0] S_EDGE  = 4'd5;
  localparam logic [3:0] S_TGT   = 4'd6;
  localparam logic [3:0] S_PHEAD = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_HCLR  = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;
  localparam logic [3:0] S_MARK  = 4'd11;

  localparam int NW = dgcd_pkg::NODE_W;
  localparam int LW = dgcd_pkg::LINK_W;
  localparam int EDGE_A = dgcd_pkg::EDGE_W;

  // Memories: head list with epoch-free clearing pass, edge store, stack, marks.
  logic [LW-1:0] head_mem [dgcd_pkg::NODES];
  logic [NW-1:0] tgt_mem  [dgcd_pkg::EDGES];
  logic [LW-1:0] link_mem [dgcd_pkg::EDGES];
  logic [NW-1:0] stk_node [dgcd_pkg::NODES];
  logic [LW-1:0] stk_cur  [dgcd_pkg::NODES];
  logic          seen_mem [dgcd_pkg::NODES];
  logic          path_mem [dgcd_pkg::NODES];

  logic [3:0]    state_r;
  logic [LW-1:0] total_r;
  logic          ovf_r;
  logic [NW:0]   cnt_r;     // clear sweep and root counter
  logic [NW:0]   depth_r;
  logic [NW-1:0] node_r;    // node at top or new target
  logic [LW-1:0] cur_r;
  logic          cyc_r;
  logic          done_r;
  logic [NW-1:0] src_r, dst_r;

  // Registered memory read data.
  logic [LW-1:0] head_q, link_q, scur_q;
  logic [NW-1:0] tgt_q, snode_q;
  logic          seen_q, path_q;

  logic [NW-1:0] head_ra, mark_ra;
  logic [EDGE_A-1:0] edge_ra;
  logic [NW-1:0] top_idx;

  assign top_idx = depth_r[NW-1:0] - 1'b1;

  // The target read back from the edge store addresses its head and marks directly.
  always_comb begin
    head_ra = node_r;
    if (state_r == S_ROOT) head_ra = cnt_r[NW-1:0];
    else if (state_r == S_IDLE) head_ra = src;
    else if (state_r == S_PHEAD) head_ra = tgt_q;
    mark_ra = node_r;
    if (state_r == S_ROOT) mark_ra = cnt_r[NW-1:0];
    else if (state_r == S_PHEAD) mark_ra = tgt_q;
    edge_ra = EDGE_A'(cur_r - 1'b1);
  end

  // Synchronous reads.
  always_ff @(posedge clk) begin
    head_q  <= head_mem[head_ra];
    tgt_q   <= tgt_mem[edge_ra];
    link_q  <= link_mem[edge_ra];
    seen_q  <= seen_mem[mark_ra];
    path_q  <= path_mem[mark_ra];
    snode_q <= stk_node[top_idx];
    scur_q  <= stk_cur[top_idx];
  end

  // Control and memory writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HCLR;
      cnt_r   <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
      cyc_r   <= 1'b0;
      depth_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == S_DONE);
      case (state_r)
        S_HCLR: begin
          head_mem[cnt_r[NW-1:0]] <= '0;
          if (cnt_r[NW-1:0] == NW'(dgcd_pkg::NODES - 1)) begin
            state_r <= S_IDLE;
            cnt_r   <= '0;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            src_r <= src;
            dst_r <= dst;
            case (op)
              dgcd_pkg::OP_ADD: begin
                if (total_r == LW'(dgcd_pkg::EDGES)) ovf_r <= 1'b1;
                else state_r <= S_ADD;
              end
              dgcd_pkg::OP_RUN: begin
                cnt_r <= '0;
                cyc_r <= 1'b0;
                state_r <= S_CLRM;
              end
              dgcd_pkg::OP_CLEAR: begin
                total_r <= '0;
                ovf_r   <= 1'b0;
                cnt_r   <= '0;
                state_r <= S_HCLR;
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          tgt_mem[total_r[EDGE_A-1:0]]  <= dst_r;
          link_mem[total_r[EDGE_A-1:0]] <= head_q;
          head_mem[src_r] <= total_r + 1'b1;
          total_r <= total_r + 1'b1;
          state_r <= S_IDLE;
        end
        S_CLRM: begin
          seen_mem[cnt_r[NW-1:0]] <= 1'b0;
          path_mem[cnt_r[NW-1:0]] <= 1'b0;
          if (cnt_r[NW-1:0] == NW'(dgcd_pkg::NODES - 1)) begin
            cnt_r   <= (NW+1)'(1);
            state_r <= S_ROOT;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_ROOT: begin
          // Issue reads for root cnt_r.
          if (cnt_r > {1'b0, last_root}) state_r <= S_DONE;
          else begin
            node_r  <= cnt_r[NW-1:0];
            state_r <= S_RHEAD;
          end
        end
        S_RHEAD: begin
          if (seen_q) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_ROOT;
          end else begin
            seen_mem[node_r] <= 1'b1;
            path_mem[node_r] <= 1'b1;
            stk_node[0] <= node_r;
            stk_cur[0]  <= head_q;
            depth_r <= (NW+1)'(1);
            state_r <= S_TOP;
          end
        end
        S_TOP: begin
          // Stack read of the top entry is issued here; its data is used in S_EDGE.
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          if (scur_q == '0 || scur_q > total_r) begin
            path_mem[snode_q] <= 1'b0;
            depth_r <= depth_r - 1'b1;
            if (depth_r == (NW+1)'(1)) begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_ROOT;
            end else state_r <= S_TOP;
          end else begin
            cur_r   <= scur_q;
            state_r <= S_TGT;
          end
        end
        S_TGT: begin
          // Edge read issued; target capture and cursor advance follow in S_PHEAD.
          state_r <= S_PHEAD;
        end
        S_PHEAD: begin
          node_r <= tgt_q;
          stk_cur[top_idx] <= link_q;
          state_r <= S_MARK;
        end
        S_MARK: begin
          // Marks and head of node_r are now valid.
          if (!seen_q) begin
            seen_mem[node_r] <= 1'b1;
            path_mem[node_r] <= 1'b1;
            stk_node[depth_r[NW-1:0]] <= node_r;
            stk_cur[depth_r[NW-1:0]]  <= head_q;
            depth_r <= depth_r + 1'b1;
            state_r <= S_TOP;
          end else if (path_q) begin
            cyc_r   <= 1'b1;
            state_r <= S_DONE;
          end else state_r <= S_TOP;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign ovf       = ovf_r;
  assign sts.done  = done_r;
  assign sts.cycle = cyc_r;
endmodule
`default_nettype wire

@@ rtl/core/directed_graph_cycle_detect_unit.sv @@
// Top level of the directed graph cycle detector: handshakes and result register.
//
// Usage: requests arrive on the in_ stream, tdata = {to_node, from_node, opcode}
// from the high bit down. Opcode add edge stores one edge, clear empties the graph
// by sweeping all 256 list heads, and run searches the graph depth-first and
// returns one result on the out_ stream, tdata = {edges_dropped, cycle_found}.
// A run first sweeps the marks of all 256 nodes, then takes each root in turn,
// skipping a root already visited, following edges and leaving nodes; the result
// passes through the done register into the output register when the search
// ends. The memories are read synchronously.
// One request is handled at a time; in_tready is low while the engine works
// or while a finished result is being registered or waits in the output register.
// After reset the list heads are swept clear before the first request is taken;
// configuration writes are always accepted.
// A stalled receiver holds the result in the output register.
`default_nettype none
module directed_graph_cycle_detect_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [23:0] in_tdata,   // opcode[1:0], from_node[9:2], to_node[17:10]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // cycle_found[0], edges_dropped[1]
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  logic [7:0] node_count_r;
  logic [7:0] last_root;
  logic       busy, ovf, accept;
  logic       res_v_r;
  logic [1:0] res_r;
  dgcd_pkg::srch_sts_t sts;

  assign cfg_ready = 1'b1;
  assign last_root = (node_count_r == 8'hFF) ? 8'hFF : node_count_r;
  assign in_tready = !busy && !res_v_r && !sts.done;
  assign accept    = in_tvalid && in_tready;

  // Node count register.
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= '0;
    else if (cfg_valid) node_count_r <= cfg_data;
  end

  dgcd_engine u_engine (
    .clk(clk), .rst_n(rst_n), .start(accept),
    .op(in_tdata[1:0]), .src(in_tdata[9:2]), .dst(in_tdata[17:10]),
    .last_root(last_root), .busy(busy), .ovf(ovf), .sts(sts)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) res_v_r <= 1'b0;
    else if (sts.done) begin
      res_v_r <= 1'b1;
      res_r   <= {ovf, sts.cycle};
    end else if (out_tready) res_v_r <= 1'b0;
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {6'd0, res_r};

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !res_v_r) else $error("result overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> !in_tready) else $error("accept while result pending");
`endif
endmodule
`default_nettype wire

@@ sim/directed_graph_cycle_detect_unit_test.sv @@
// Self-checking testbench for the directed graph cycle detector.
module directed_graph_cycle_detect_unit_test;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 320;
  localparam int STALL_LIMIT = 60000;
  localparam int ITEM_GOAL = 1250;

  typedef struct packed {
    logic cycle;
    logic dropped;
  } verdict_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [1:0] op;
    logic [7:0] src;
    logic [7:0] dst;
    logic typed;
    verdict_t verdict;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;   // opcode[1:0], from_node[9:2], to_node[17:10]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;        // cycle_found[0], edges_dropped[1]
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  // Predictor state for the loaded graph.
  logic [10:0] adj_head [dgcd_pkg::NODES];
  logic [7:0] edge_dst [dgcd_pkg::EDGES];
  logic [10:0] edge_next [dgcd_pkg::EDGES];
  int edge_cnt;
  logic dropped_flag;
  logic [7:0] root_limit;

  verdict_t pending_verdicts[$];
  int fails = 0;
  int item_count = 0;
  int run_count = 0;
  int cycles_seen = 0;
  int drops_seen = 0;
  bit quiet = 1'b0;
  int stall_count = 0;

  directed_graph_cycle_detect_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void graph_clear();
    for (int i = 0; i < dgcd_pkg::NODES; i++) adj_head[i] = '0;
    edge_cnt = 0;
    dropped_flag = 1'b0;
  endfunction

  function automatic void graph_add_edge(logic [7:0] src, logic [7:0] dst);
    if (edge_cnt >= dgcd_pkg::EDGES) begin
      dropped_flag = 1'b1;
      return;
    end
    edge_dst[edge_cnt] = dst;
    edge_next[edge_cnt] = adj_head[src];
    adj_head[src] = 11'(edge_cnt + 1);
    edge_cnt++;
  endfunction

  // Depth-first search from every unseen root 1..root_limit with an explicit stack.
  function automatic logic graph_has_cycle();
    bit seen [dgcd_pkg::NODES];
    bit onpath [dgcd_pkg::NODES];
    int stk_node [dgcd_pkg::NODES];
    int stk_cur [dgcd_pkg::NODES];
    int depth, top, cur, t;
    for (int r = 1; r <= int'(root_limit); r++) begin
      if (seen[r]) continue;
      depth = 1;
      stk_node[0] = r;
      stk_cur[0] = adj_head[r];
      seen[r] = 1'b1;
      onpath[r] = 1'b1;
      while (depth > 0) begin
        top = depth - 1;
        cur = stk_cur[top];
        if (cur == 0 || cur > edge_cnt) begin
          onpath[stk_node[top]] = 1'b0;
          depth--;
          continue;
        end
        t = edge_dst[cur-1];
        stk_cur[top] = edge_next[cur-1];
        if (!seen[t]) begin
          seen[t] = 1'b1;
          onpath[t] = 1'b1;
          stk_node[depth] = t;
          stk_cur[depth] = adj_head[t];
          depth++;
        end else if (onpath[t]) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Receiver readiness changes on the falling edge.
  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 24);
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: tdata=%h", out_tdata);
        fails++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.cycle) begin
          $error("cycle_found: expected %0d, actual %0d", want.cycle, out_tdata[0]);
          fails++;
        end
        if (out_tdata[1] !== want.dropped) begin
          $error("edges_dropped: expected %0d, actual %0d", want.dropped, out_tdata[1]);
          fails++;
        end
        cycles_seen += out_tdata[0];
        drops_seen += out_tdata[1];
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
      if (stall_count > STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", stall_count);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Sends one request; called and returns on a falling edge.
  task automatic send_req(logic [1:0] op, logic [7:0] src, logic [7:0] dst,
                          logic typed = 1'b0, verdict_t given = '0);
    verdict_t v;
    while (!quiet && $urandom_range(99) < 24) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {6'b0, dst, src, op};
    do @(posedge clk); while (!in_tready);
    case (op)
      dgcd_pkg::OP_ADD: graph_add_edge(src, dst);
      dgcd_pkg::OP_CLEAR: graph_clear();
      dgcd_pkg::OP_RUN: begin
        v.cycle = graph_has_cycle();
        v.dropped = dropped_flag;
        pending_verdicts = {pending_verdicts, (typed ? given : v)};
        run_count++;
      end
      default: ;
    endcase
    if (op != OP_UNUSED) item_count++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Waits until all results are in and the engine has had time to finish.
  task automatic settle();
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_roots(logic [7:0] val);
    settle();
    cfg_valid = 1'b1;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    root_limit = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  stim_row_t directed [25] = '{
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b1, 2'b00},     // run right after reset
    '{ROW_CFG, dgcd_pkg::OP_ADD, 8'd0, 8'd255, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b1, 2'b00},     // empty graph, all roots
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd1, 8'd1, 1'b0, 2'b00},     // self loop
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b1, 2'b10},
    '{ROW_CFG, dgcd_pkg::OP_ADD, 8'd0, 8'd0, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b1, 2'b00},     // no roots scanned
    '{ROW_CFG, dgcd_pkg::OP_ADD, 8'd0, 8'd1, 1'b0, 2'b00},
    '{ROW_REQ, OP_UNUSED, 8'hff, 8'hff, 1'b0, 2'b00},          // ignored opcode
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_CLEAR, 8'hff, 8'hff, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd0, 8'd0, 1'b0, 2'b00},     // node 0 is never a root
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd255, 8'd255, 1'b0, 2'b00},
    '{ROW_CFG, dgcd_pkg::OP_ADD, 8'd0, 8'd255, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b0, 2'b00},
    '{ROW_CFG, dgcd_pkg::OP_ADD, 8'd0, 8'd254, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd1, 8'd2, 1'b0, 2'b00},     // diamond, no cycle
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd1, 8'd3, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd2, 8'd4, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd3, 8'd4, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b0, 2'b00},
    '{ROW_REQ, dgcd_pkg::OP_ADD, 8'd4, 8'd1, 1'b0, 2'b00},     // closes a long cycle
    '{ROW_REQ, dgcd_pkg::OP_RUN, 8'd0, 8'd0, 1'b0, 2'b00}
  };

  initial begin
    int phase;
    int span, nedges;
    logic [7:0] roots;
    graph_clear();
    root_limit = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_roots(directed[i].dst);
      else send_req(directed[i].op, directed[i].src, directed[i].dst,
                    directed[i].typed, directed[i].verdict);
    end

    phase = 0;
    while (item_count < ITEM_GOAL) begin
      quiet = (phase >= 6 && phase < 16);
      case ($urandom_range(5))
        0: roots = 8'd0;
        1: roots = 8'd255;
        2: roots = 8'd1;
        default: roots = 8'($urandom_range(20));
      endcase
      write_roots(roots);
      if (phase == 3) begin
        // Fill the edge store past capacity over the whole node range.
        send_req(dgcd_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
        for (int k = 0; k < dgcd_pkg::EDGES + 6; k++)
          send_req(dgcd_pkg::OP_ADD, 8'($urandom), 8'($urandom));
        send_req(dgcd_pkg::OP_RUN, 8'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(3) != 0)
          send_req(dgcd_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
        span = ($urandom_range(9) == 0) ? 255 : $urandom_range(1, 15);
        repeat ($urandom_range(1, 4)) begin
          nedges = $urandom_range(1, 12);
          for (int k = 0; k < nedges; k++) begin
            if ($urandom_range(19) == 0)
              send_req(OP_UNUSED, 8'($urandom), 8'($urandom));
            send_req(dgcd_pkg::OP_ADD, 8'($urandom_range(span)), 8'($urandom_range(span)));
          end
          send_req(dgcd_pkg::OP_RUN, 8'($urandom), 8'($urandom));
        end
      end
      phase++;
    end
    quiet = 1'b0;

    settle();
    $display("covered %0d requests and %0d runs over %0d phases", item_count, run_count, phase);
    $display("runs reporting a cycle: %0d, reporting dropped edges: %0d", cycles_seen, drops_seen);
    if (fails == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
